@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL of the octant table angle unit.
// Define SYNTH to compile them away; nothing else is required.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AOTA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AOTA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AOTA_ASSERT(lbl, clk, rst_n, prop)
`define AOTA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/aota_pkg.sv @@
// Package of the octant table angle unit: constants, codes and the word types
// passed along the divider chain and to the table. Depends on nothing.
`default_nettype none
package aota_pkg;
    localparam int TABLE_DEPTH = 257;
    localparam int ADDR_W      = 9;
    localparam int QUO_W       = 9;
    localparam int MAG_W       = 17;
    localparam int REM_W       = 24;
    localparam int DIV_W       = REM_W + 1;
    localparam int NUM_CELLS   = QUO_W;
    localparam int SHIFT_LO    = 6;
    localparam int SHIFT_HI    = 8;

    localparam logic [15:0] QUAD_LO = 16'd64;
    localparam logic [15:0] QUAD_HI = 16'd512;
    localparam logic [QUO_W-1:0]  QUO_MAX  = 9'd256;
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TABLE_DEPTH - 1);

    localparam logic OP_ANGLE    = 1'b0;
    localparam logic OP_WRITE    = 1'b1;
    localparam logic MODE_COARSE = 1'b0;
    localparam logic MODE_FINE   = 1'b1;

    typedef struct packed {
        logic              is_write;
        logic              mode;
        logic              negative;
        logic [15:0]       offset;
        logic              zero;
        logic [REM_W-1:0]  rem;
        logic [DIV_W-1:0]  div;
        logic [QUO_W-1:0]  quo;
        logic [ADDR_W-1:0] entry_index;
        logic [15:0]       entry_value;
    } t_cell_word;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [15:0]       wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_tbl_req;
endpackage
`default_nettype wire

@@ rtl/core/aota_div_cell.sv @@
// One cell of the divider chain: resolves one quotient bit per word and
// hands the word to its neighbor. Depends on aota_pkg.
`default_nettype none
module aota_div_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  aota_pkg::t_cell_word i_word,
    input  wire                 i_go,
    output logic                o_valid,
    output aota_pkg::t_cell_word o_word,
    output logic                o_go
);
    import aota_pkg::*;

    logic       r_valid;
    t_cell_word r_word;
    t_cell_word n_word;
    logic       w_bit;

    assign o_go    = !r_valid || i_go;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        w_bit = !i_word.zero && ({1'b0, i_word.rem} >= i_word.div);
        n_word = i_word;
        if (w_bit) begin
            n_word.rem = REM_W'({1'b0, i_word.rem} - i_word.div);
        end
        n_word.div = i_word.div >> 1;
        n_word.quo = {i_word.quo[QUO_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_go) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_go && i_valid) begin
            r_word <= n_word;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/aota_octant_table.sv @@
// Octant angle table: one write port and one read port with registered
// read data. Depends on aota_pkg.
`default_nettype none
module aota_octant_table (
    input  wire               i_clk,
    input  aota_pkg::t_tbl_req i_req,
    output logic [15:0]       o_rd_data
);
    import aota_pkg::*;

    logic [15:0] r_mem [TABLE_DEPTH];
    logic [15:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/atan2_octant_table_angle_unit.sv @@
// Binary angle of a signed vector by octant reduction, division chain and
// table lookup. One word enters per cycle while o_ready is high; results pass
// an octant reduction register, nine divider cells (one quotient bit each),
// one table read and one output register. Table write words travel the same
// path, so writes and lookups stay in arrival order. Depends on aota_pkg,
// aota_div_cell, aota_octant_table and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module atan2_octant_table_angle_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_data,
    output logic        o_cfg_ready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_opcode,
    input  wire  [15:0] i_vec_x,
    input  wire  [15:0] i_vec_y,
    input  wire  [8:0]  i_entry_index,
    input  wire  [15:0] i_entry_value,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_angle
);
    import aota_pkg::*;

    logic r_mode;

    logic       r_p_valid;
    t_cell_word r_p_word;
    t_cell_word n_p_word;
    logic       w_p_go;

    logic [MAG_W-1:0] w_mx;
    logic [MAG_W-1:0] w_my;
    logic [MAG_W-1:0] w_major;
    logic [MAG_W-1:0] w_minor;
    logic [15:0]      w_quad;
    logic             w_swap;

    logic       w_valid [NUM_CELLS+1];
    t_cell_word w_word  [NUM_CELLS+1];
    logic       w_go    [NUM_CELLS+1];

    logic        r_t_valid;
    logic        r_t_negative;
    logic        r_t_mode;
    logic [15:0] r_t_offset;
    logic        w_t_go;
    t_tbl_req    w_tbl_req;
    logic [15:0] w_rd_data;
    logic [15:0] w_acc;

    logic        r_o_valid;
    logic        r_o_mode;
    logic [15:0] r_o_angle;
    logic        w_o_go;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COARSE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_comb begin
        w_mx    = i_vec_x[15] ? MAG_W'(17'h10000 - {1'b0, i_vec_x}) : {1'b0, i_vec_x};
        w_my    = i_vec_y[15] ? MAG_W'(17'h10000 - {1'b0, i_vec_y}) : {1'b0, i_vec_y};
        w_swap  = w_mx < w_my;
        w_major = w_swap ? w_my : w_mx;
        w_minor = w_swap ? w_mx : w_my;
        w_quad  = (r_mode == MODE_FINE) ? QUAD_HI : QUAD_LO;

        n_p_word          = '0;
        n_p_word.is_write = (i_opcode == OP_WRITE);
        n_p_word.mode     = r_mode;
        n_p_word.offset   = i_vec_x[15] ? 16'(w_quad << 1) : 16'd0;
        n_p_word.negative = i_vec_x[15] ^ i_vec_y[15];
        if (w_swap) begin
            n_p_word.offset = n_p_word.negative ? 16'(n_p_word.offset - w_quad)
                                                : 16'(n_p_word.offset + w_quad);
            n_p_word.negative = !n_p_word.negative;
        end
        n_p_word.zero = (w_major == '0);
        n_p_word.rem  = (r_mode == MODE_FINE) ? REM_W'(REM_W'(w_minor) << SHIFT_HI)
                                              : REM_W'(REM_W'(w_minor) << SHIFT_LO);
        n_p_word.div  = {w_major, 8'd0};
        n_p_word.quo  = '0;
        n_p_word.entry_index = i_entry_index;
        n_p_word.entry_value = i_entry_value;
    end

    assign w_p_go  = !r_p_valid || w_go[0];
    assign o_ready = w_p_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_go) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_go && i_valid) begin
            r_p_word <= n_p_word;
        end
    end

    assign w_valid[0] = r_p_valid;
    assign w_word[0]  = r_p_word;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        aota_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .i_go    (w_go[g+1]),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1]),
            .o_go    (w_go[g])
        );
    end

    assign w_o_go = !r_o_valid || i_ready;
    assign w_t_go = !r_t_valid || w_o_go;
    assign w_go[NUM_CELLS] = w_t_go;

    always_comb begin
        w_tbl_req.wr_en   = w_t_go && w_valid[NUM_CELLS] && w_word[NUM_CELLS].is_write
                            && (w_word[NUM_CELLS].entry_index <= ADDR_MAX);
        w_tbl_req.wr_addr = w_word[NUM_CELLS].entry_index;
        w_tbl_req.wr_data = w_word[NUM_CELLS].entry_value;
        w_tbl_req.rd_en   = w_t_go && w_valid[NUM_CELLS] && !w_word[NUM_CELLS].is_write;
        w_tbl_req.rd_addr = (w_word[NUM_CELLS].quo > ADDR_MAX) ? ADDR_MAX
                                                               : w_word[NUM_CELLS].quo;
    end

    aota_octant_table u_table (
        .i_clk     (i_clk),
        .i_req     (w_tbl_req),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_t_go) begin
            r_t_valid <= w_valid[NUM_CELLS] && !w_word[NUM_CELLS].is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_req.rd_en) begin
            r_t_negative <= w_word[NUM_CELLS].negative;
            r_t_mode     <= w_word[NUM_CELLS].mode;
            r_t_offset   <= w_word[NUM_CELLS].offset;
        end
    end

    assign w_acc = r_t_negative ? 16'(r_t_offset - w_rd_data) : 16'(r_t_offset + w_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_go) begin
            r_o_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_go && r_t_valid) begin
            r_o_mode  <= r_t_mode;
            r_o_angle <= (r_t_mode == MODE_FINE) ? w_acc : {8'd0, w_acc[7:0]};
        end
    end

    assign o_valid = r_o_valid;
    assign o_angle = r_o_angle;

    `AOTA_ASSERT(a_coarse_narrow, i_clk, i_rst_n, r_o_valid && (r_o_mode == MODE_COARSE) |-> (r_o_angle[15:8] == 8'd0))
    `AOTA_NEVER(a_port_clash, i_clk, i_rst_n, w_tbl_req.wr_en && w_tbl_req.rd_en)
    `AOTA_ASSERT(a_quo_range, i_clk, i_rst_n, w_valid[NUM_CELLS] && !w_word[NUM_CELLS].is_write |-> (w_word[NUM_CELLS].quo <= QUO_MAX))
    `AOTA_ASSERT(a_lookup_holds, i_clk, i_rst_n, r_o_valid && !i_ready && r_t_valid |=> r_t_valid && $stable(r_t_offset) && $stable(w_rd_data))
endmodule
`default_nettype wire

@@ dv/atan2_octant_table_angle_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of atan2_octant_table_angle_unit: loads the octant table, then
// checks every angle against a scoreboard that predicts it, with random idling on both sides.
// Depends on aota_pkg and the unit's RTL only.
module atan2_octant_table_angle_unit_tb;
    import aota_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 20;

    class angle_scoreboard;
        bit [15:0]   octant_lut [TABLE_DEPTH];
        logic        mode = MODE_COARSE;
        logic [15:0] angle_q [$];
        int          errors = 0;

        function void note_word(logic op, logic [15:0] x, logic [15:0] y,
                                logic [8:0] ei, logic [15:0] ev);
            logic [16:0] mx, my, major, minor;
            logic [15:0] quad, offset, acc;
            int unsigned scale, idx;
            logic        negative;
            if (op == OP_WRITE) begin
                if (ei < TABLE_DEPTH) octant_lut[ei] = ev;
                return;
            end
            mx = x[15] ? 17'h10000 - {1'b0, x} : {1'b0, x};
            my = y[15] ? 17'h10000 - {1'b0, y} : {1'b0, y};
            quad = (mode == MODE_FINE) ? 16'd512 : 16'd64;
            scale = (mode == MODE_FINE) ? 256 : 64;
            offset = x[15] ? quad * 16'd2 : 16'd0;
            negative = x[15] ^ y[15];
            major = mx;
            minor = my;
            if (mx < my) begin
                offset = negative ? offset - quad : offset + quad;
                negative = !negative;
                major = my;
                minor = mx;
            end
            idx = (major == 0) ? 0 : (scale * minor) / major;
            if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
            acc = negative ? offset - octant_lut[idx] : offset + octant_lut[idx];
            if (mode == MODE_COARSE) acc[15:8] = 8'h00;
            angle_q.push_back(acc);
        endfunction

        function void check_angle(logic [15:0] got);
            logic [15:0] want;
            if (angle_q.size() == 0) begin
                $display("%0t: unexpected angle word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = angle_q.pop_front();
            if (got !== want) begin
                $display("%0t: angle mismatch, expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return angle_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_opcode = 1'b0;
    logic [15:0] i_vec_x = '0;
    logic [15:0] i_vec_y = '0;
    logic [8:0]  i_entry_index = '0;
    logic [15:0] i_entry_value = '0;
    logic        i_ready = 1'b0;
    wire         o_cfg_ready;
    wire         o_ready;
    wire         o_valid;
    wire  [15:0] o_angle;

    angle_scoreboard sb = new;
    logic steady = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;

    atan2_octant_table_angle_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_angle       (o_angle)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
            5, 6: v = $urandom_range(0, 16) - 8;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 0;
                    3: v = 16'hFFFF;
                    default: v = 1;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("atan2_octant_table_angle_unit_tb NOT OK");
            $finish;
        end else begin
            if (i_rst_n && o_valid === 1'b1 && i_ready) sb.check_angle(o_angle);
            if (hold_left != 0 && !steady) begin
                i_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                i_ready <= 1'b1;
                hold_left <= ($urandom_range(0, 9) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic send_word(logic op, logic [15:0] x, logic [15:0] y,
                             logic [8:0] ei, logic [15:0] ev);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_vec_x <= x;
        i_vec_y <= y;
        i_entry_index <= ei;
        i_entry_value <= ev;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_word(op, x, y, ei, ev);
    endtask

    task automatic send_angle(logic [15:0] x, logic [15:0] y);
        send_word(OP_ANGLE, x, y, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_entry(logic [8:0] ei, logic [15:0] ev);
        send_word(OP_WRITE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  ei, ev);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        logic [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            steady = ((i / 100) % 4 == 2);
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 4) == 0)
                    send_entry(9'($urandom_range(TABLE_DEPTH, 511)),
                               16'($urandom_range(0, 65535)));
                else
                    send_entry(9'($urandom_range(0, TABLE_DEPTH - 1)),
                               16'($urandom_range(0, 65535)));
            end else begin
                x = rand_coord();
                y = rand_coord();
                case ($urandom_range(0, 19))
                    0: y = x;
                    1: y = -x;
                    default: ;
                endcase
                send_angle(x, y);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(MODE_COARSE);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_entry(i[8:0], 16'($urandom_range(0, 65535)));

        send_angle(16'h0000, 16'h0000);
        send_angle(16'h7FFF, 16'h0000);
        send_angle(16'h8000, 16'h0000);
        send_angle(16'h0000, 16'h8000);
        send_angle(16'h8000, 16'h8000);
        send_angle(16'h7FFF, 16'h7FFF);
        send_angle(16'h8000, 16'h7FFF);
        send_angle(16'h7FFF, 16'h8000);
        send_angle(16'h0001, 16'hFFFF);
        send_angle(16'hFFFF, 16'h0001);
        send_angle(16'h0000, 16'h0005);
        send_angle(16'h0003, 16'hFFF9);
        send_angle(16'hFFF9, 16'hFFFD);
        send_entry(9'd300, 16'h1234);
        send_entry(9'h1FF, 16'hFFFF);
        send_entry(9'd0, 16'hFFFF);
        send_angle(16'h0000, 16'h0000);
        send_entry(9'd0, 16'h0000);
        send_angle(16'h0004, 16'h0000);

        for (int p = 0; p < 4; p++) begin
            drain();
            write_mode((p % 2 == 0) ? MODE_FINE : MODE_COARSE);
            random_items(406);
        end
        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("atan2_octant_table_angle_unit_tb OK");
        else
            $display("atan2_octant_table_angle_unit_tb NOT OK");
        $finish;
    end
endmodule
